### rtl/core/palr_pkg.sv
// Package for the path arc-length resampler: widths, defaults, shared types.
// No dependencies.
`timescale 1ns / 1ps
package palr_pkg;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned MaxSamplesDef = 32;
  localparam int unsigned SpBits = 23;
  localparam int unsigned RemBits = 24;
  localparam int unsigned AddrBits = 2;
  localparam logic [AddrBits-1:0] RegSpacing = 2'd0;
  localparam int unsigned QDepth = 2;

  // back-end state machine
  typedef enum logic [3:0] {
    BkIdle, BkSq, BkRoot, BkLen, BkStart, BkDivK, BkPlan, BkMul, BkDiv, BkOut
  } bk_state_e;
endpackage

### rtl/core/palr_front.sv
// Front end: takes vertices, classifies path starts and queues vertices.
// Depends on palr_pkg.
`timescale 1ns / 1ps
module palr_front #(
  parameter int unsigned CoordBits = palr_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic                        path_start_i,
  output logic                        q_valid_o,
  input  logic                        q_pop_i,
  output logic signed [CoordBits-1:0] q_x_o,
  output logic signed [CoordBits-1:0] q_y_o,
  output logic                        q_start_o
);
  import palr_pkg::*;

  localparam int unsigned W = 2 * CoordBits + 1;
  logic [W-1:0] mem_q [QDepth];
  logic         wp_q, rp_q, wp_d, rp_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         have_prev_q;
  logic         push;

  assign in_stall_o = (cnt_q == 2'(QDepth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign {q_x_o, q_y_o, q_start_o} = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q ^ push;
    rp_d = rp_q ^ q_pop_i;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  // entry write: missing start is treated as start
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {point_x_i, point_y_i, path_start_i || !have_prev_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; have_prev_q <= 1'b0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
      if (push) have_prev_q <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop on empty queue");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid_o) else $error("stall while empty");
endmodule

### rtl/core/palr_back.sv
// Back end: segment length by bit-serial sqrt, sample count by serial
// division, interpolation by one multiply and a serial divide per axis of each sample.
// Depends on palr_pkg.
`timescale 1ns / 1ps
module palr_back #(
  parameter int unsigned CoordBits  = palr_pkg::CoordBitsDef,
  parameter int unsigned MaxSamples = palr_pkg::MaxSamplesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [palr_pkg::SpBits-1:0] spacing_i,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  logic signed [CoordBits-1:0] q_x_i,
  input  logic signed [CoordBits-1:0] q_y_i,
  input  logic                        q_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordBits-1:0] out_x_o,
  output logic signed [CoordBits-1:0] out_y_o,
  output logic                        last_of_run_o,
  output logic                        samples_dropped_o
);
  import palr_pkg::*;

  localparam int unsigned DW = CoordBits + 1;        // delta width
  localparam int unsigned MW = CoordBits;            // magnitude width
  localparam int unsigned LW = MW + 1;               // length width
  localparam int unsigned SQW = 2 * LW;              // sum of squares, even for 2-bit steps
  localparam int unsigned NW = 2 * LW + 1;           // numerator width
  localparam int unsigned KW = LW;                   // count width
  localparam int unsigned PW = LW + MW;              // product width
  localparam int unsigned SCW = $clog2(NW + 1);
  localparam int unsigned JW = $clog2(MaxSamples + 1);

  bk_state_e st_q, st_d;
  logic signed [CoordBits-1:0] px_q, py_q, nx_q, ny_q;
  logic start_pend_q;
  logic [RemBits-1:0] rem_q;
  logic [SpBits-1:0] sp_q;
  logic [MW-1:0] ax_q, ay_q;
  logic sx_q, sy_q;
  logic [SQW-1:0] rad_q;
  logic [LW-1:0] root_q, len_q;
  logic [SQW-1:0] rr_q;
  logic [SCW-1:0] cnt_q;
  logic [NW-1:0] num_q, qt_q;
  logic [LW-1:0] dr_q;
  logic [JW-1:0] j_q, emit_q;
  logic [LW-1:0] pos_q;
  logic dropped_q, axis_q;
  logic signed [CoordBits-1:0] ox_q, oy_q, rx_q, ry_q;
  logic ov_q, olast_q, odrop_q;
  logic [LW-1:0] sp_ext, rem_ext;
  logic [SQW+1:0] trial;
  logic [LW:0] dtrial;
  logic [PW-1:0] prod_w;
  logic [NW-1:0] prod;
  logic plan_hit, plan_drop, emit_now;
  logic [KW-1:0] plan_k;
  logic [JW-1:0] plan_emit;

  assign sp_ext = LW'(sp_q);
  assign rem_ext = LW'(rem_q);
  assign trial = {rr_q, rad_q[SQW-1 -: 2]} - (SQW+2)'({root_q, 2'b01});
  assign dtrial = {dr_q, num_q[NW-1]} - {1'b0, (st_q == BkDivK) ? sp_ext : len_q};
  assign prod_w = pos_q * (axis_q ? ay_q : ax_q);
  assign prod = NW'(prod_w);
  assign q_pop_o = (st_q == BkIdle) && q_valid_i && (q_start_i || 1'b1) && !ov_q;

  // sample count for the segment, known in the plan state
  assign plan_hit = (rem_ext <= len_q);
  assign plan_k = KW'(qt_q) + KW'(1);
  assign plan_drop = plan_hit && (plan_k > KW'(MaxSamples));
  assign plan_emit = !plan_hit ? '0 : plan_drop ? JW'(MaxSamples) : JW'(plan_k);

  // a result is loaded into the output register
  assign emit_now = ((st_q == BkStart) || (st_q == BkOut)) && (!ov_q || !out_stall_i);

  assign out_valid_o = ov_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign last_of_run_o = olast_q;
  assign samples_dropped_o = odrop_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:  if (q_pop_o && !q_start_i) st_d = BkSq;
      BkSq:    st_d = BkRoot;
      BkRoot:  if (cnt_q == '0) st_d = BkLen;
      BkLen:   st_d = BkDivK;
      BkDivK:  if (cnt_q == '0) st_d = BkPlan;
      BkPlan:  st_d = start_pend_q ? BkStart : (plan_emit == '0) ? BkIdle : BkMul;
      BkStart: if (!ov_q || !out_stall_i) st_d = (emit_q == '0) ? BkIdle : BkMul;
      BkMul:   st_d = BkDiv;
      BkDiv:   if (cnt_q == '0) st_d = axis_q ? BkOut : BkMul;
      BkOut:   if (!ov_q || !out_stall_i) st_d = (j_q + JW'(1) == emit_q) ? BkIdle : BkMul;
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BkIdle;
    else st_q <= st_d;
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; start_pend_q <= 1'b0; rem_q <= '0; ov_q <= 1'b0;
      olast_q <= 1'b0; odrop_q <= 1'b0; emit_q <= '0;
    end else begin
      if (emit_now) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (st_q)
        BkIdle: if (q_pop_o) begin
          sp_q <= (spacing_i == '0) ? SpBits'(1) : spacing_i;
          nx_q <= q_x_i; ny_q <= q_y_i;
          if (q_start_i) begin
            px_q <= q_x_i; py_q <= q_y_i; start_pend_q <= 1'b1;
            rem_q <= RemBits'((spacing_i == '0) ? SpBits'(1) : spacing_i);
          end else begin
            begin : dlt
              logic signed [DW-1:0] dx, dy;
              dx = DW'(q_x_i) - DW'(px_q);
              dy = DW'(q_y_i) - DW'(py_q);
              sx_q <= dx[DW-1]; sy_q <= dy[DW-1];
              ax_q <= MW'(dx[DW-1] ? -dx : dx);
              ay_q <= MW'(dy[DW-1] ? -dy : dy);
            end
          end
        end
        BkSq: begin
          rad_q <= SQW'(ax_q * ax_q) + SQW'(ay_q * ay_q);
          rr_q <= '0; root_q <= '0; cnt_q <= SCW'(LW - 1);
        end
        BkRoot: begin
          rad_q <= rad_q << 2;
          if (!trial[SQW+1]) begin
            rr_q <= trial[SQW-1:0]; root_q <= {root_q[LW-2:0], 1'b1};
          end else begin
            rr_q <= {rr_q[SQW-3:0], rad_q[SQW-1 -: 2]}; root_q <= {root_q[LW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - SCW'(1);
        end
        BkLen: begin
          len_q <= root_q;
          // numerator for k: len - rem when rem <= len
          num_q <= (rem_ext <= root_q) ? NW'(root_q - rem_ext) << (NW - LW) : '0;
          dr_q <= '0; qt_q <= '0; cnt_q <= SCW'(LW - 1);
        end
        BkDivK: begin
          num_q <= num_q << 1;
          if (!dtrial[LW]) begin
            dr_q <= dtrial[LW-1:0]; qt_q <= {qt_q[NW-2:0], 1'b1};
          end else begin
            dr_q <= {dr_q[LW-2:0], num_q[NW-1]}; qt_q <= {qt_q[NW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - SCW'(1);
        end
        BkPlan: begin
          rem_q <= plan_hit ? RemBits'(sp_ext - dr_q) : RemBits'(rem_ext - len_q);
          emit_q <= plan_emit; dropped_q <= plan_drop;
          pos_q <= rem_ext;
          j_q <= '0; axis_q <= 1'b0;
          // nothing to emit for this vertex: advance now
          if (plan_emit == '0 && !start_pend_q) begin
            px_q <= nx_q; py_q <= ny_q;
          end
        end
        BkStart: if (!ov_q || !out_stall_i) begin
          ox_q <= px_q; oy_q <= py_q; start_pend_q <= 1'b0;
          olast_q <= (emit_q == '0); odrop_q <= dropped_q;
          if (emit_q == '0) begin
            px_q <= nx_q; py_q <= ny_q;
          end
        end
        BkMul: begin
          num_q <= prod + NW'(len_q >> 1);
          dr_q <= '0; qt_q <= '0; cnt_q <= SCW'(NW - 1);
        end
        BkDiv: begin
          num_q <= num_q << 1;
          if (!dtrial[LW]) begin
            dr_q <= dtrial[LW-1:0]; qt_q <= {qt_q[NW-2:0], 1'b1};
          end else begin
            dr_q <= {dr_q[LW-2:0], num_q[NW-1]}; qt_q <= {qt_q[NW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - SCW'(1);
          // result held aside until the output register is free
          if (cnt_q == '0) begin
            if (!axis_q) begin
              rx_q <= sx_q ? px_q - CoordBits'(qt_q << 1 | NW'(!dtrial[LW]))
                           : px_q + CoordBits'(qt_q << 1 | NW'(!dtrial[LW]));
              axis_q <= 1'b1;
            end else begin
              ry_q <= sy_q ? py_q - CoordBits'(qt_q << 1 | NW'(!dtrial[LW]))
                           : py_q + CoordBits'(qt_q << 1 | NW'(!dtrial[LW]));
            end
          end
        end
        BkOut: if (!ov_q || !out_stall_i) begin
          ox_q <= rx_q; oy_q <= ry_q;
          olast_q <= (j_q + JW'(1) == emit_q); odrop_q <= dropped_q;
          j_q <= j_q + JW'(1); axis_q <= 1'b0;
          pos_q <= pos_q + LW'(sp_q);
          if (j_q + JW'(1) == emit_q) begin
            px_q <= nx_q; py_q <= ny_q;
          end
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q) else $error("result lost under stall");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == BkIdle) else $error("pop while busy");
  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= JW'(MaxSamples)) else $error("emit count over cap");
endmodule

### rtl/core/path_arc_length_resampler_core.sv
// Path arc-length resampler top level: APB register, front queue, back end.
// Sequence: a path-start vertex is absorbed in the idle state. Other vertices
// go through length (bit-serial sqrt) and sample count (serial divide); a
// pending start point appears then, then the samples, each needing two serial
// divides (one per axis). A new vertex is popped only once the back end is idle.
// Reset (async, active low) clears state; spacing returns to 1.0.
`timescale 1ns / 1ps
module path_arc_length_resampler_core #(
  parameter int unsigned CoordBits  = palr_pkg::CoordBitsDef,
  parameter int unsigned FracBits   = palr_pkg::FracBitsDef,
  parameter int unsigned MaxSamples = palr_pkg::MaxSamplesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [palr_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [CoordBits-1:0]  point_x_i,
  input  logic signed [CoordBits-1:0]  point_y_i,
  input  logic                         path_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [CoordBits-1:0]  out_x_o,
  output logic signed [CoordBits-1:0]  out_y_o,
  output logic                         last_of_run_o,
  output logic                         samples_dropped_o
);
  import palr_pkg::*;

  logic [SpBits-1:0] spacing_q;
  logic q_valid, q_pop, q_start;
  logic signed [CoordBits-1:0] q_x, q_y;

  assign pready = 1'b1;
  assign prdata = (paddr == RegSpacing) ? 32'(spacing_q) : 32'd0;

  // spacing register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spacing_q <= SpBits'(1) << FracBits;
    else if (psel && penable && pwrite && paddr == RegSpacing) spacing_q <= pwdata[SpBits-1:0];
  end

  palr_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .point_x_i, .point_y_i, .path_start_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_x_o(q_x), .q_y_o(q_y), .q_start_o(q_start)
  );

  palr_back #(.CoordBits(CoordBits), .MaxSamples(MaxSamples)) u_back (
    .clk_i, .rst_ni, .spacing_i(spacing_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_x_i(q_x), .q_y_i(q_y), .q_start_i(q_start), .out_valid_o, .out_stall_i,
    .out_x_o, .out_y_o, .last_of_run_o, .samples_dropped_o
  );
endmodule

### tb/sv/tb_path_arc_length_resampler_core.sv
// Testbench for path_arc_length_resampler_core: random and directed polyline vertices in,
// resampled points checked against a built-in arc-length predictor. Depends on palr_pkg.
`timescale 1ns / 1ps
module tb_path_arc_length_resampler_core;
  import palr_pkg::*;

  localparam int unsigned MaxPerSeg = 32;
  localparam int WatchLimit = 40000;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    bit                 start;
  } vertex_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    bit                 last;
    bit                 drop;
  } sample_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = RegSpacing;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [23:0]  point_x_i = '0, point_y_i = '0;
  logic                path_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [23:0]  out_x_o, out_y_o;
  logic                last_of_run_o, samples_dropped_o;

  path_arc_length_resampler_core u_top (.*);

  // vertices waiting to be sent, samples waiting to come back
  vertex_t vertex_q[$];
  sample_t sample_q[$];

  // predictor state
  logic [22:0] spacing_reg = 23'd256;
  logic signed [23:0] last_x = '0, last_y = '0;
  bit  have_last = 1'b0, start_owed = 1'b0;
  logic [23:0] dist_left = '0;

  int tx_idle_pct = 10, rx_idle_pct = 83;
  int sent_cnt = 0, acc_cnt = 0, got_cnt = 0, drop_cnt = 0, err_cnt = 0;
  int quiet_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // prev + sign(d) * round(pos*|d|/len), half away from zero
  function automatic logic signed [23:0] lerp_coord(longint p0, longint d,
                                                     longint unsigned pos,
                                                     longint unsigned len);
    logic [127:0] num;
    longint q;
    if (len == 0) return p0[23:0];
    num = 128'(pos) * 128'(d < 0 ? -d : d) + 128'(len >> 1);
    q = longint'(num / 128'(len));
    return (d < 0) ? 24'(p0 - q) : 24'(p0 + q);
  endfunction

  // expected samples for one accepted vertex
  task automatic resample_vertex(vertex_t v);
    logic [23:0] sp, rem;
    longint dx, dy;
    longint unsigned len, k, emit, pos;
    sample_t run[$];
    sample_t s;
    sp = (spacing_reg == 0) ? 24'd1 : {1'b0, spacing_reg};
    rem = dist_left;
    if (v.start || !have_last) begin
      last_x = v.x; last_y = v.y;
      have_last = 1'b1; start_owed = 1'b1;
      dist_left = sp;
      return;
    end
    dx = longint'(v.x) - longint'(last_x);
    dy = longint'(v.y) - longint'(last_y);
    len = root_floor(longint'(dx * dx + dy * dy));
    k = 0;
    if (rem <= len) begin
      k = (len - rem) / sp + 1;
      dist_left = 24'(sp - (len - rem) % sp);
    end else begin
      dist_left = 24'(rem - len);
    end
    emit = (k > MaxPerSeg) ? MaxPerSeg : k;
    s.drop = (k > MaxPerSeg);
    s.last = 1'b0;
    if (start_owed) begin
      s.x = last_x; s.y = last_y;
      run.push_back(s);
    end
    for (longint unsigned j = 0; j < emit; j++) begin
      pos = rem + j * sp;
      s.x = lerp_coord(last_x, dx, pos, len);
      s.y = lerp_coord(last_y, dy, pos, len);
      run.push_back(s);
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) sample_q.push_back(run[i]);
    last_x = v.x; last_y = v.y;
    start_owed = 1'b0;
  endtask

  // input driver: new request only once the previous one was taken
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    if (sent_cnt == acc_cnt) begin
      if (rst_ni && vertex_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i   <= 1'b1;
        point_x_i    <= vertex_q[0].x;
        point_y_i    <= vertex_q[0].y;
        path_start_i <= vertex_q[0].start;
        sent_cnt     <= sent_cnt + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // accept, predict and check
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      resample_vertex(vertex_q.pop_front());
      acc_cnt <= acc_cnt + 1;
    end
    if (out_valid_o && !out_stall_i) begin
      got_cnt <= got_cnt + 1;
      if (samples_dropped_o) drop_cnt <= drop_cnt + 1;
      if (sample_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected sample x=%0d y=%0d", out_x_o, out_y_o);
      end else begin
        sample_t e;
        e = sample_q.pop_front();
        if (out_x_o !== e.x || out_y_o !== e.y || last_of_run_o !== e.last ||
            samples_dropped_o !== e.drop) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: exp x=%0d y=%0d last=%0b drop=%0b, got x=%0d y=%0d last=%0b drop=%0b",
                     e.x, e.y, e.last, e.drop, out_x_o, out_y_o, last_of_run_o,
                     samples_dropped_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_vertex(longint x, longint y, bit s);
    vertex_t v;
    v.x = 24'(x); v.y = 24'(y); v.start = s;
    vertex_q.push_back(v);
  endtask

  task automatic drain();
    while (vertex_q.size() > 0 || sent_cnt != acc_cnt || sample_q.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_spacing(logic [31:0] val);
    drain();
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= RegSpacing; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    spacing_reg = val[22:0];
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint rand_signed(longint mag);
    if (mag <= 0) return 0;
    return longint'($urandom_range(32'(2 * mag))) - mag;
  endfunction

  // a path walked with steps scaled to the spacing, then a pause until idle
  task automatic random_path(int nv);
    longint cx, cy, step, sp;
    int r;
    sp = (spacing_reg == 0) ? 1 : spacing_reg;
    cx = longint'($urandom_range(8388607)) - 4194304;
    cy = longint'($urandom_range(8388607)) - 4194304;
    add_vertex(cx, cy, $urandom_range(9) != 0);
    for (int i = 0; i < nv; i++) begin
      r = $urandom_range(99);
      step = (r < 10) ? 0 : (r < 55) ? sp : (r < 88) ? 4 * sp : 40 * sp;
      if (step > 4194304) step = 4194304;
      cx = clamp_coord(cx + rand_signed(step));
      cy = clamp_coord(cy + rand_signed(step));
      add_vertex(cx, cy, 1'b0);
    end
    drain();
  endtask

  initial begin
    logic [31:0] spacings[6];
    spacings = '{32'd256, 32'd8388607, 32'd1, 32'd0, 32'd1000, 32'd0};
    spacings[5] = $urandom_range(64, 4096);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: missing start after reset, extremes, zero length, capped segment
    add_vertex(0, 0, 1'b0);
    add_vertex(0, 0, 1'b0);
    add_vertex(1000, 0, 1'b0);
    add_vertex(1000, -700, 1'b0);
    add_vertex(-8388608, -8388608, 1'b1);
    add_vertex(8388607, 8388607, 1'b0);
    add_vertex(8388607, -8388608, 1'b0);
    add_vertex(-8388608, 8388607, 1'b0);
    add_vertex(5, 5, 1'b1);
    add_vertex(77, 77, 1'b1);
    add_vertex(77, 333, 1'b0);
    add_vertex(77, 333, 1'b0);
    add_vertex(-300, 333, 1'b0);
    add_vertex(-300, 5000, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 83 : 0;
      rx_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 10 : 0;
      if (ph > 0) write_spacing(spacings[ph] | (32'($urandom_range(1)) << 31));
      // continuation across a spacing change
      if (ph > 0) add_vertex(last_x + 600, last_y - 300, 1'b0);
      // noise: full-range vertices, random start flag
      for (int i = 0; i < 6; i++)
        add_vertex(longint'($urandom_range(16777215)) - 8388608,
                   longint'($urandom_range(16777215)) - 8388608, $urandom_range(1));
      drain();
      for (int p = 0; p < 7; p++) random_path($urandom_range(3, 7));
    end

    drain();
    repeat (500) @(posedge clk_i);
    $display("Run covered %0d vertices and %0d samples (%0d flagged as capped)",
             acc_cnt, got_cnt, drop_cnt);
    $display("over six spacing settings including minimum, maximum and zero; %0d mismatches",
             err_cnt);
    if (err_cnt == 0 && sample_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/palr_pkg.sv
rtl/core/palr_front.sv
rtl/core/palr_back.sv
rtl/core/path_arc_length_resampler_core.sv
tb/sv/tb_path_arc_length_resampler_core.sv
